// ===== rtl/core/utf8_sanitizer_assert.svh =====
// assertion helpers shared by the sanitizer modules
`ifndef UTF8_SANITIZER_ASSERT_SVH
`define UTF8_SANITIZER_ASSERT_SVH

// property that must hold at every clock edge out of reset
`define UTF8S_ASSERT_ALWAYS(lbl, ck, rstn, cond) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (cond)) \
    else $error("utf8 sanitizer: invariant violated");

// same-cycle implication
`define UTF8S_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("utf8 sanitizer: implication violated");

// next-cycle implication
`define UTF8S_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("utf8 sanitizer: next-cycle check violated");

`endif

// ===== rtl/core/utf8s_pkg.sv =====
`default_nettype none

package utf8s_pkg;

  localparam logic [7:0] SUBST_CHAR = 8'h3F;

  // most results one byte can release: three held bytes plus itself
  localparam int MAX_RES    = 4;
  localparam int MAX_HELD   = 3;
  localparam int OUTQ_DEPTH = 8;

  typedef struct packed {
    logic [2:0]            n;      // number of result bytes, 0..4
    logic [MAX_RES-1:0][7:0] bytes;
    logic                  last;   // final byte of the string is among them
  } step_res_t;

endpackage

`default_nettype wire

// ===== rtl/core/utf8s_step.sv =====
`default_nettype none

`include "utf8_sanitizer_assert.svh"

module utf8s_step (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  fire,
  input  logic [7:0]            cur_byte,
  input  logic                  cur_last,
  output utf8s_pkg::step_res_t  res
);
  import utf8s_pkg::*;

  localparam logic [7:0] CONT_LO  = 8'h80;
  localparam logic [7:0] CONT_HI  = 8'hBF;
  localparam logic [7:0] LEAD_E0  = 8'hE0;
  localparam logic [7:0] LEAD_ED  = 8'hED;
  localparam logic [7:0] LEAD_F0  = 8'hF0;
  localparam logic [7:0] LEAD_F4  = 8'hF4;
  localparam logic [7:0] LEAD_MIN = 8'hC2;
  localparam logic [7:0] LEAD2_MAX = 8'hDF;
  localparam logic [7:0] LEAD3_MAX = 8'hEF;

  logic [7:0] held_r   [MAX_HELD];
  logic [7:0] held_nxt [MAX_HELD];
  logic [1:0] hc_r, hc_nxt;
  logic [2:0] seq_r, seq_nxt;

  logic [7:0] lo, hi;
  logic       holding, fits, complete, extend, fresh;
  logic       f_lead, f_emit;
  logic [7:0] f_byte, mid_byte;
  logic [2:0] f_len, pre_n, tail_n;
  logic       mid_emit;
  logic [1:0] hc_mid;
  logic [MAX_RES-1:0][7:0] hold_vec;

  always_comb begin
    lo = CONT_LO;
    hi = CONT_HI;
    if (hc_r == 2'd1) begin
      case (held_r[0])
        LEAD_E0: lo = 8'hA0;
        LEAD_ED: hi = 8'h9F;
        LEAD_F0: lo = 8'h90;
        LEAD_F4: hi = 8'h8F;
        default: ;
      endcase
    end
    fits     = (cur_byte >= lo) && (cur_byte <= hi);
    holding  = (hc_r != 2'd0);
    complete = holding && fits && (({1'b0, hc_r} + 3'd1) >= seq_r);
    extend   = holding && fits && !complete;
    fresh    = !holding || !fits;

    // fresh judgement of the current byte
    f_lead = (cur_byte >= LEAD_MIN) && (cur_byte <= LEAD_F4);
    f_emit = !f_lead;
    f_byte = ((cur_byte == 8'h00) || cur_byte[7]) ? SUBST_CHAR : cur_byte;
    f_len  = (cur_byte <= LEAD2_MAX) ? 3'd2 : (cur_byte <= LEAD3_MAX) ? 3'd3 : 3'd4;

    pre_n    = (complete || (holding && !fits)) ? {1'b0, hc_r} : 3'd0;
    mid_emit = complete || (fresh && f_emit);
    mid_byte = complete ? cur_byte : f_byte;

    held_nxt = held_r;
    hc_mid   = hc_r;
    seq_nxt  = seq_r;
    if (complete) begin
      hc_mid  = 2'd0;
      seq_nxt = 3'd0;
    end else if (extend) begin
      case (hc_r)
        2'd1:    held_nxt[1] = cur_byte;
        2'd2:    held_nxt[2] = cur_byte;
        default: ;
      endcase
      hc_mid = hc_r + 2'd1;
    end else if (f_lead) begin
      held_nxt[0] = cur_byte;
      hc_mid      = 2'd1;
      seq_nxt     = f_len;
    end else begin
      hc_mid  = 2'd0;
      seq_nxt = 3'd0;
    end

    // string end: whatever is still held turns into substitutes
    tail_n = cur_last ? {1'b0, hc_mid} : 3'd0;
    hc_nxt = hc_mid;
    if (cur_last) begin
      hc_nxt  = 2'd0;
      seq_nxt = 3'd0;
    end

    hold_vec = {SUBST_CHAR, held_r[2], held_r[1], held_r[0]};
    for (int i = 0; i < MAX_RES; i++) begin
      if (complete && (3'(i) < {1'b0, hc_r})) begin
        res.bytes[i] = hold_vec[i];
      end else if (mid_emit && (3'(i) == pre_n)) begin
        res.bytes[i] = mid_byte;
      end else begin
        res.bytes[i] = SUBST_CHAR;
      end
    end
    res.n    = fire ? (pre_n + {2'b00, mid_emit} + tail_n) : 3'd0;
    res.last = fire && cur_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r  <= 2'd0;
      seq_r <= 3'd0;
    end else if (fire) begin
      hc_r  <= hc_nxt;
      seq_r <= seq_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_r <= held_nxt;
    end
  end

  `UTF8S_ASSERT_IMP(a_hold_len, clk, rst_n, hc_r != 2'd0, (seq_r > 3'(hc_r)) && (seq_r <= 3'd4))
  `UTF8S_ASSERT_NEXT(a_last_clears, clk, rst_n, fire && cur_last, hc_r == 2'd0)
  `UTF8S_ASSERT_IMP(a_last_emits, clk, rst_n, fire && cur_last, res.n != 3'd0)

endmodule

`default_nettype wire

// ===== rtl/core/utf8s_outq.sv =====
`default_nettype none

`include "utf8_sanitizer_assert.svh"

module utf8s_outq #(
  parameter int DEPTH = utf8s_pkg::OUTQ_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  utf8s_pkg::step_res_t res,
  output logic                 room,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import utf8s_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = AW + 1;

  logic [8:0]    entry_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          pop;

  assign room      = (cnt_r <= CW'(DEPTH - MAX_RES));
  assign out_valid = (cnt_r != '0);
  assign pop       = out_valid && !out_stall;
  assign out_byte  = entry_r[rd_ptr_r][7:0];
  assign out_last  = entry_r[rd_ptr_r][8];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + AW'(res.n);
    rd_ptr_nxt = rd_ptr_r + AW'(pop);
    cnt_nxt    = cnt_r + CW'(res.n) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // end-of-string flag rides only on the final byte of the request
  always_ff @(posedge clk) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (3'(j) < res.n) begin
        entry_r[wr_ptr_r + AW'(j)] <= {res.last && (3'(j) == (res.n - 3'd1)), res.bytes[j]};
      end
    end
  end

  `UTF8S_ASSERT_ALWAYS(a_cnt_bound, clk, rst_n, cnt_r <= CW'(DEPTH))
  `UTF8S_ASSERT_IMP(a_push_room, clk, rst_n, res.n != 3'd0, room)

endmodule

`default_nettype wire

// ===== rtl/core/utf8_sanitizer.sv =====
// channel | direction | payload            | handshake
// in_     | input     | in_byte, in_last   | in_valid / in_stall
// out_    | output    | out_byte, out_last | out_valid / out_stall
//
// one byte accepted per cycle while in_stall is low; an accepted byte is judged while it sits in
// the input register and the queue has room, and its results are written into the output queue
// a completed or broken sequence releases up to four bytes at once into an
// output queue of OUTQ_DEPTH entries that drains one byte per cycle while out_stall is low
// in_stall rises while a request waits and the queue has fewer than four free entries
// rst_n is synchronous, active low, and empties the held sequence and queue
`default_nettype none

module utf8_sanitizer #(
  parameter int OUTQ_DEPTH = utf8s_pkg::OUTQ_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_last
);
  import utf8s_pkg::*;

  logic       in_valid_r, in_valid_nxt;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       accept, step_fire, q_room;
  step_res_t  res;

  assign step_fire = in_valid_r && q_room;
  assign in_stall  = in_valid_r && !q_room;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    in_valid_nxt = in_valid_r;
    if (accept) begin
      in_valid_nxt = 1'b1;
    end else if (step_fire) begin
      in_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else begin
      in_valid_r <= in_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_byte_r <= in_byte;
      in_last_r <= in_last;
    end
  end

  utf8s_step u_step (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (step_fire),
    .cur_byte (in_byte_r),
    .cur_last (in_last_r),
    .res      (res)
  );

  utf8s_outq #(
    .DEPTH (OUTQ_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (res),
    .room      (q_room),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

`default_nettype wire

// ===== dv/utf8_sanitizer_tb.sv =====
`timescale 1ns / 100ps

module utf8_sanitizer_tb;
  import utf8s_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } text_byte_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_last;

  utf8_sanitizer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_byte  (in_byte),
    .in_last  (in_last),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_byte (out_byte),
    .out_last (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  text_byte_t text_q[$];      // bytes waiting to be sent
  text_byte_t clean_q[$];     // sanitized bytes still to come out
  text_byte_t word_q[$];      // one string under construction
  int         n_total = 0;
  int         n_accepted = 0;
  int         errors = 0;

  // sanitizer state as seen by the predictor
  logic [7:0] seq_bytes [3];
  int         seq_held = 0;
  int         seq_len = 0;

  function automatic bit cont_fits(logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = 8'h80;
    hi = 8'hBF;
    if (seq_held == 1) begin
      case (seq_bytes[0])
        8'hE0: lo = 8'hA0;
        8'hED: hi = 8'h9F;
        8'hF0: lo = 8'h90;
        8'hF4: hi = 8'h8F;
        default: ;
      endcase
    end
    return (b >= lo) && (b <= hi);
  endfunction

  task automatic emit_clean(logic [7:0] d);
    clean_q.push_back('{data: d, last: 1'b0});
  endtask

  task automatic drop_sequence();
    for (int i = 0; i < seq_held; i++) emit_clean(SUBST_CHAR);
    seq_held = 0;
    seq_len = 0;
  endtask

  task automatic start_char(logic [7:0] b);
    if (b == 8'h00) begin
      emit_clean(SUBST_CHAR);
    end else if (b < 8'h80) begin
      emit_clean(b);
    end else if (b >= 8'hC2 && b <= 8'hF4) begin
      seq_bytes[0] = b;
      seq_held = 1;
      seq_len = (b <= 8'hDF) ? 2 : (b <= 8'hEF) ? 3 : 4;
    end else begin
      emit_clean(SUBST_CHAR);
    end
  endtask

  task automatic sanitize_byte(logic [7:0] b, logic eos);
    int         start;
    text_byte_t tail;
    start = clean_q.size();
    if (seq_held > 0) begin
      if (cont_fits(b)) begin
        if (seq_held + 1 >= seq_len) begin
          for (int i = 0; i < seq_held; i++) emit_clean(seq_bytes[i]);
          emit_clean(b);
          seq_held = 0;
          seq_len = 0;
        end else begin
          seq_bytes[seq_held] = b;
          seq_held++;
        end
      end else begin
        drop_sequence();
        start_char(b);
      end
    end else begin
      start_char(b);
    end
    if (eos) begin
      drop_sequence();
      if (clean_q.size() > start) begin
        tail = clean_q.pop_back();
        tail.last = 1'b1;
        clean_q.push_back(tail);
      end
    end
  endtask

  // idle percentages per phase: sender light first, then receiver light, then none
  function automatic int phase_of();
    return (n_total == 0) ? 2 : (n_accepted * 3) / n_total;
  endfunction

  always @(posedge clk) begin : driver
    text_byte_t item;
    int         idle_pct;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        sanitize_byte(in_byte, in_last);
        n_accepted++;
      end
      case (phase_of())
        0: idle_pct = 17;
        1: idle_pct = 49;
        default: idle_pct = 0;
      endcase
      if (!in_valid || !in_stall) begin
        if (text_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
          item = text_q.pop_front();
          in_valid <= 1'b1;
          in_byte <= item.data;
          in_last <= item.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : monitor
    text_byte_t want;
    int         stall_pct;
    if (rst_n && out_valid && !out_stall) begin
      if (clean_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected output byte %h last %b", out_byte, out_last);
      end else begin
        want = clean_q.pop_front();
        if (want.data !== out_byte || want.last !== out_last) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: expected byte %h last %b, got byte %h last %b",
                     want.data, want.last, out_byte, out_last);
        end
      end
    end
    case (phase_of())
      0: stall_pct = 49;
      1: stall_pct = 17;
      default: stall_pct = 0;
    endcase
    out_stall <= rst_n && ($urandom_range(99) < stall_pct);
  end

  task automatic add_byte(logic [7:0] d, logic eos);
    text_q.push_back('{data: d, last: eos});
  endtask

  function automatic logic [7:0] pick_second(logic [7:0] lead);
    case (lead)
      8'hE0: return 8'($urandom_range(8'hBF, 8'hA0));
      8'hED: return 8'($urandom_range(8'h9F, 8'h80));
      8'hF0: return 8'($urandom_range(8'hBF, 8'h90));
      8'hF4: return 8'($urandom_range(8'h8F, 8'h80));
      default: return 8'($urandom_range(8'hBF, 8'h80));
    endcase
  endfunction

  task automatic add_word_byte(logic [7:0] d);
    word_q.push_back('{data: d, last: 1'b0});
  endtask

  // one character: mostly well formed, some truncated or broken, some noise
  task automatic add_random_char();
    logic [7:0] lead;
    logic [7:0] second;
    int         kind;
    int         len;
    int         keep;
    kind = $urandom_range(99);
    if (kind < 30) begin
      add_word_byte(($urandom_range(99) < 4) ? 8'h00 : 8'($urandom_range(127, 1)));
    end else if (kind < 72 || kind < 84) begin
      if (kind < 45 || (kind >= 72 && $urandom_range(2) == 0)) begin
        lead = 8'($urandom_range(8'hDF, 8'hC2));
        len = 2;
      end else if (kind < 60 || (kind >= 72 && $urandom_range(1) == 0)) begin
        lead = 8'($urandom_range(8'hEF, 8'hE0));
        len = 3;
      end else begin
        lead = 8'($urandom_range(8'hF4, 8'hF0));
        len = 4;
      end
      // truncated sequences keep only a prefix
      keep = (kind >= 72) ? $urandom_range(len - 1, 1) : len;
      add_word_byte(lead);
      if (keep > 1) add_word_byte(pick_second(lead));
      for (int i = 2; i < keep; i++) add_word_byte(8'($urandom_range(8'hBF, 8'h80)));
    end else if (kind < 92) begin
      // lead followed by a second byte out of its allowed range
      lead = 8'($urandom_range(8'hF4, 8'hC2));
      do begin
        second = 8'($urandom_range(255));
        seq_len = 0;
      end while (
        (lead == 8'hE0) ? (second >= 8'hA0 && second <= 8'hBF) :
        (lead == 8'hED) ? (second >= 8'h80 && second <= 8'h9F) :
        (lead == 8'hF0) ? (second >= 8'h90 && second <= 8'hBF) :
        (lead == 8'hF4) ? (second >= 8'h80 && second <= 8'h8F) :
                          (second >= 8'h80 && second <= 8'hBF));
      add_word_byte(lead);
      add_word_byte(second);
    end else begin
      add_word_byte(8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    text_byte_t item;
    int         n_chars;
    // plain ascii, nul, del, bad leads, stray continuation
    add_byte(8'h41, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h7F, 1'b0);
    add_byte(8'hC0, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'h80, 1'b0);
    // good two and three byte forms
    add_byte(8'hC2, 1'b0);
    add_byte(8'hA9, 1'b0);
    add_byte(8'hE0, 1'b0);
    add_byte(8'hA0, 1'b0);
    add_byte(8'h80, 1'b0);
    // surrogate, above the top code point, and a good four byte form
    add_byte(8'hED, 1'b0);
    add_byte(8'hA0, 1'b0);
    add_byte(8'hF4, 1'b0);
    add_byte(8'h90, 1'b0);
    add_byte(8'hF0, 1'b0);
    add_byte(8'h9F, 1'b0);
    add_byte(8'h98, 1'b0);
    add_byte(8'h80, 1'b0);
    // overlong three byte form
    add_byte(8'hE0, 1'b0);
    add_byte(8'h9F, 1'b0);
    // sequence cut off by the end of string
    add_byte(8'hF1, 1'b0);
    add_byte(8'h80, 1'b0);
    add_byte(8'h80, 1'b1);
    add_byte(8'hF5, 1'b1);

    seq_len = 0;
    while (text_q.size() < 95) begin
      n_chars = $urandom_range(6, 1);
      for (int c = 0; c < n_chars; c++) add_random_char();
      while (word_q.size() > 0) begin
        item = word_q.pop_front();
        item.last = (word_q.size() == 0);
        text_q.push_back(item);
      end
    end
    n_total = text_q.size();

    rst_n = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    do @(negedge clk); while (n_accepted < n_total || clean_q.size() != 0);
    repeat (20) @(posedge clk);
    if (errors == 0 && clean_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #1000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
